// ===== rtl/core/imhq_pkg.sv =====
// ----------------------------------------------------------------------------
// imhq_pkg
// Shared types and constants for the indexed max-heap queue: command and
// status codes, the cell row control word and the result beat layout.
// ----------------------------------------------------------------------------
package imhq_pkg;

  localparam int ID_W         = 8;
  localparam int ID_COUNT     = 256;
  localparam int COUNT_W      = 9;
  localparam int STATUS_W     = 2;
  localparam int CAPACITY_DEF = 256;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_POLL   = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_DUP   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_POLL   = 2'd2
  } cell_op_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_t          op;
    logic [ID_W-1:0]   id;
  } cell_ctrl_t;

  typedef struct packed {
    logic              is_empty;
    logic [COUNT_W-1:0] count;
    status_t           status;
    logic [ID_W-1:0]   out_id;
  } result_t;

endpackage

// ===== rtl/core/imhq_cell.sv =====
// ----------------------------------------------------------------------------
// imhq_cell
// One slot of the sorted id row. Keeps its id, takes the new id, or takes
// the id of the neighbor above (insert) or below (poll).
// ----------------------------------------------------------------------------
module imhq_cell
  import imhq_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  cell_ctrl_t      ctrl,
  input  logic            up_gt,
  input  logic [ID_W-1:0] up_key,
  input  logic            up_valid,
  input  logic [ID_W-1:0] dn_key,
  input  logic            dn_valid,
  output logic [ID_W-1:0] key,
  output logic            valid,
  output logic            gt
);

  logic [ID_W-1:0] key_r;
  logic [ID_W-1:0] key_nxt;
  logic            valid_r;
  logic            valid_nxt;

  // held id outranks the incoming one: stay put
  assign gt = valid_r && (key_r > ctrl.id);

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    case (ctrl.op)
      OP_INSERT: begin
        if (gt) begin
          key_nxt   = key_r;
          valid_nxt = valid_r;
        end else if (up_gt) begin
          key_nxt   = ctrl.id;
          valid_nxt = 1'b1;
        end else begin
          key_nxt   = up_key;
          valid_nxt = up_valid;
        end
      end
      OP_POLL: begin
        key_nxt   = dn_key;
        valid_nxt = dn_valid;
      end
      default: begin
        key_nxt   = key_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key   = key_r;
  assign valid = valid_r;

endmodule

// ===== rtl/core/imhq_map.sv =====
// ----------------------------------------------------------------------------
// imhq_map
// Presence flag per id, cleared at reset; answers whether an id is held.
// ----------------------------------------------------------------------------
module imhq_map
  import imhq_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [ID_W-1:0] rd_id,
  output logic            rd_hit,
  input  logic            set_en,
  input  logic [ID_W-1:0] set_id,
  input  logic            clr_en,
  input  logic [ID_W-1:0] clr_id
);

  logic [ID_COUNT-1:0] present_r;
  logic [ID_COUNT-1:0] present_nxt;

  assign rd_hit = present_r[rd_id];

  always_comb begin
    present_nxt = present_r;
    if (set_en) begin
      present_nxt[set_id] = 1'b1;
    end
    if (clr_en) begin
      present_nxt[clr_id] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else begin
      present_r <= present_nxt;
    end
  end

endmodule

// ===== rtl/core/imhq_obuf.sv =====
// ----------------------------------------------------------------------------
// imhq_obuf
// Result register with one skid slot, so a new command is taken while a
// result still waits at the output.
// ----------------------------------------------------------------------------
module imhq_obuf
  import imhq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    push_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    out_valid_r;
  logic    out_valid_nxt;
  logic    skid_valid_r;
  logic    skid_valid_nxt;
  result_t out_data_r;
  result_t out_data_nxt;
  result_t skid_data_r;
  result_t skid_data_nxt;
  logic    pop;

  assign push_ready = !skid_valid_r;
  assign pop        = out_valid_r && out_ready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (pop) begin
      if (skid_valid_r) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        out_data_nxt   = push_data;
      end else begin
        out_valid_nxt  = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r) begin
        out_data_nxt   = push_data;
        out_valid_nxt  = 1'b1;
      end else begin
        skid_data_nxt  = push_data;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // the skid slot only fills behind a waiting result
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot holds a result with the output register empty");

  // a waiting result is not replaced before it is taken
  a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && out_data_r == $past(out_data_r)))
    else $error("stalled result changed");

endmodule

// ===== rtl/core/indexed_max_heap_queue.sv =====
// ----------------------------------------------------------------------------
// indexed_max_heap_queue
// Priority queue of distinct 8-bit ids that always yields the largest id.
// Results are registered in the output buffer before they show on out_*.
// Throughput: one command per cycle while in_tready is high; the whole cell
// row compares and shifts in parallel, so no walk over heap levels is needed.
// Reset: clears the cell valid bits, the presence flags and the count at
// once; there is no clearing pass, commands are taken right after reset.
// ----------------------------------------------------------------------------
module indexed_max_heap_queue
  import imhq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // command channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] item_id
  input  logic [0:0]  in_tuser,   // [0] cmd
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_id, [16:8] count, [17] is_empty
  output logic [1:0]  out_tuser   // [1:0] status
);

  // distinct ids never exceed the id space, so the row is capped there
  localparam int DEPTH = (CAPACITY < ID_COUNT) ? CAPACITY : ID_COUNT;

  // ---------------------------------------------------------------------------
  // command decode
  // ---------------------------------------------------------------------------
  logic               in_acc;
  cmd_t               cmd;
  logic [ID_W-1:0]    cmd_id;
  logic               is_full;
  logic               is_none;
  logic               id_hit;

  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;

  cell_ctrl_t         ctrl;
  result_t            res;
  logic               set_en;
  logic               clr_en;

  // cell row taps
  logic [ID_W-1:0]    key_q [DEPTH];
  logic [DEPTH-1:0]   valid_q;
  logic [DEPTH-1:0]   gt_q;

  assign in_acc  = in_tvalid && in_tready;
  assign cmd     = cmd_t'(in_tuser[0]);
  assign cmd_id  = in_tdata[ID_W-1:0];
  assign is_full = (32'(count_r) >= 32'(CAPACITY));
  assign is_none = (count_r == '0);

  always_comb begin
    ctrl.op    = OP_HOLD;
    ctrl.id    = cmd_id;
    count_nxt  = count_r;
    set_en     = 1'b0;
    clr_en     = 1'b0;
    res.out_id = '0;
    res.status = ST_OK;
    if (in_acc) begin
      case (cmd)
        CMD_INSERT: begin
          // full wins over duplicate
          if (is_full) begin
            res.status = ST_FULL;
          end else if (id_hit) begin
            res.status = ST_DUP;
          end else begin
            ctrl.op   = OP_INSERT;
            count_nxt = count_r + COUNT_W'(1);
            set_en    = 1'b1;
          end
        end
        CMD_POLL: begin
          if (is_none) begin
            res.status = ST_EMPTY;
          end else begin
            // head cell holds the largest id; the row shifts up behind it
            ctrl.op    = OP_POLL;
            count_nxt  = count_r - COUNT_W'(1);
            clr_en     = 1'b1;
            res.out_id = key_q[0];
          end
        end
        default: begin
          res.status = ST_OK;
        end
      endcase
    end
    res.count    = count_nxt;
    res.is_empty = (count_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // presence flags, the position map reduced to held / not held
  // ---------------------------------------------------------------------------
  imhq_map u_map (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_id  (cmd_id),
    .rd_hit (id_hit),
    .set_en (set_en),
    .set_id (cmd_id),
    .clr_en (clr_en),
    .clr_id (key_q[0])
  );

  // ---------------------------------------------------------------------------
  // sorted row of cells, largest id in cell 0, held ids packed at the front
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic            up_gt;
    logic [ID_W-1:0] up_key;
    logic            up_valid;
    logic [ID_W-1:0] dn_key;
    logic            dn_valid;

    if (i == 0) begin : g_head
      // nothing above the head: it takes the new id unless it outranks it
      assign up_gt    = 1'b1;
      assign up_key   = '0;
      assign up_valid = 1'b0;
    end else begin : g_body
      assign up_gt    = gt_q[i-1];
      assign up_key   = key_q[i-1];
      assign up_valid = valid_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign dn_key   = '0;
      assign dn_valid = 1'b0;
    end else begin : g_link
      assign dn_key   = key_q[i+1];
      assign dn_valid = valid_q[i+1];
    end

    imhq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .up_gt    (up_gt),
      .up_key   (up_key),
      .up_valid (up_valid),
      .dn_key   (dn_key),
      .dn_valid (dn_valid),
      .key      (key_q[i]),
      .valid    (valid_q[i]),
      .gt       (gt_q[i])
    );
  end

  // ---------------------------------------------------------------------------
  // result beat buffering
  // ---------------------------------------------------------------------------
  result_t out_res;

  imhq_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_acc),
    .push_data  (res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {6'b0, out_res.is_empty, out_res.count, out_res.out_id};
  assign out_tuser = out_res.status;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  // the held count tracks the occupied cells
  a_count_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_q) == int'(count_r))
    else $error("count disagrees with occupied cells");

  // an accepted insert grows the row by exactly one
  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_INSERT) |=> (count_r == $past(count_r) + COUNT_W'(1)))
    else $error("insert did not add one id");

  // after an insert the head holds at least the inserted id
  a_insert_head: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == OP_INSERT) |=> (valid_q[0] && key_q[0] >= $past(cmd_id)))
    else $error("head below inserted id");

endmodule
